// File: hw/rtl/cah_pkg.sv
// ----------------------------------------------------------------------------
// cah_pkg
// Shared types, register indexes and exponential tables for the causal
// attention head.
// ----------------------------------------------------------------------------
package cah_pkg;

    // configuration register indexes
    localparam logic CFG_HEAD_DIM = 1'b0;
    localparam logic CFG_SCALE    = 1'b1;

    // exponent at or above 12.0 (Q.12) yields zero
    localparam logic [32:0] EXP_LIMIT = 33'd49152;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SC_RD,
        ST_SC_MAC,
        ST_SC_SCL,
        ST_SC_WR,
        ST_EX_RD,
        ST_EX_F,
        ST_EX_E,
        ST_NM_RD,
        ST_NM_LD,
        ST_NM_DIV,
        ST_NM_WR,
        ST_OUT_RD,
        ST_OUT_MAC,
        ST_OUT_EMIT
    } t_state;

    // exp(-k/16) in Q0.16, k = 0..16
    function automatic logic [16:0] exp_frac(input logic [4:0] k);
        logic [16:0] v;
        unique case (k)
            5'd0:  v = 17'd65536;
            5'd1:  v = 17'd61565;
            5'd2:  v = 17'd57835;
            5'd3:  v = 17'd54331;
            5'd4:  v = 17'd51039;
            5'd5:  v = 17'd47947;
            5'd6:  v = 17'd45042;
            5'd7:  v = 17'd42313;
            5'd8:  v = 17'd39750;
            5'd9:  v = 17'd37341;
            5'd10: v = 17'd35079;
            5'd11: v = 17'd32954;
            5'd12: v = 17'd30957;
            5'd13: v = 17'd29081;
            5'd14: v = 17'd27319;
            5'd15: v = 17'd25664;
            5'd16: v = 17'd24109;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // exp(-i) in Q0.16, i = 0..11
    function automatic logic [16:0] exp_int(input logic [3:0] i);
        logic [16:0] v;
        unique case (i)
            4'd0:  v = 17'd65536;
            4'd1:  v = 17'd24109;
            4'd2:  v = 17'd8869;
            4'd3:  v = 17'd3263;
            4'd4:  v = 17'd1200;
            4'd5:  v = 17'd442;
            4'd6:  v = 17'd162;
            4'd7:  v = 17'd60;
            4'd8:  v = 17'd22;
            4'd9:  v = 17'd8;
            4'd10: v = 17'd3;
            4'd11: v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/causal_attention_head_forward.sv
// ----------------------------------------------------------------------------
// causal_attention_head_forward
// Causal scaled dot-product attention for one head, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one element of a token's
//   query, key and value vectors per transaction. Keys and values go into
//   position memories. On the element with index D-1 the block scores the
//   query against all stored positions, runs a softmax and sends D output
//   transactions (o_out_valid / i_out_ready), the last with o_out_last set.
//   A token arriving with the memory full gives one transaction with
//   o_seq_full set. Elements with index >= D produce nothing.
// Sequencing:
//   A non-final element is only stored; the block stays ready for the next
//   one unless an output is held. A final element runs scoring, exponentials,
//   normalization (a 17-step shift/subtract divider per position) and
//   weighted value sums in turn, one position at a time through the single
//   read port of each memory. No input is taken while a token is in work.
// Reset: synchronous active low; clears the position count, state and
//   output valid; the head dimension and scale registers return to 16 and 16384.
//   Memories hold no reset value.
// Stall: a held output stops the value-sum sequencer until taken.
// ----------------------------------------------------------------------------
module causal_attention_head_forward #(
    parameter int MAX_SEQ  = 256,
    parameter int HEAD_DIM = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // configuration
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_start_sequence,
    input  logic [5:0]         i_dim_index,
    input  logic signed [15:0] i_query_elem,
    input  logic signed [15:0] i_key_elem,
    input  logic signed [15:0] i_value_elem,
    // output channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_out_elem,
    output logic [5:0]         o_out_index,
    output logic               o_out_last,
    output logic               o_seq_full
);

    localparam int SAW   = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;
    localparam int PW    = $clog2(MAX_SEQ + 1);
    localparam int AW    = (MAX_SEQ * HEAD_DIM > 1) ? $clog2(MAX_SEQ * HEAD_DIM) : 1;
    localparam int CW    = (HEAD_DIM > 1) ? $clog2(HEAD_DIM) : 1;
    localparam int DACCW = 33 + CW;
    localparam int SPW   = DACCW + 17;
    localparam int SUMW  = 17 + $clog2(MAX_SEQ + 1);
    localparam int NW    = SUMW + 17;
    localparam int OACCW = 35 + SAW;

    // registers
    cah_pkg::t_state        r_state, n_state;
    logic [6:0]             r_dim_cfg;
    logic [15:0]            r_scale;
    logic [PW-1:0]          r_pos, n_pos;
    logic [SAW-1:0]         r_j, n_j;
    logic [CW-1:0]          r_c, n_c;
    logic signed [15:0]     r_q [HEAD_DIM];
    logic signed [DACCW-1:0] r_dacc, n_dacc;
    logic signed [SPW-1:0]  r_sprod, n_sprod;
    logic signed [31:0]     r_max, n_max;
    logic [3:0]             r_i, n_i;
    logic [16:0]            r_f, n_f;
    logic                   r_ez, n_ez;
    logic [SUMW-1:0]        r_sum, n_sum;
    logic [SUMW-1:0]        r_rem, n_rem;
    logic [16:0]            r_quo, n_quo;
    logic [4:0]             r_cnt, n_cnt;
    logic signed [OACCW-1:0] r_oacc, n_oacc;
    logic                   r_out_valid, n_out_valid;
    logic signed [15:0]     r_out_elem, n_out_elem;
    logic [5:0]             r_out_index, n_out_index;
    logic                   r_out_last, n_out_last;
    logic                   r_seq_full, n_seq_full;

    // memories
    logic [15:0] key_mem [MAX_SEQ * HEAD_DIM];
    logic [15:0] val_mem [MAX_SEQ * HEAD_DIM];
    logic [31:0] sc_mem  [MAX_SEQ];
    logic [15:0] r_kdata, r_vdata;
    logic [31:0] r_sdata;

    // combinational helpers
    logic [6:0]        dim;
    logic              in_acc;
    logic [PW-1:0]     pos_eff;
    logic              kv_we;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic              sc_we;
    logic [31:0]       sc_wdata;
    logic              j_last, c_last;
    logic signed [31:0] qk;
    logic signed [SPW-1:0] sr;
    logic signed [31:0] s32;
    logic signed [32:0] nexp;
    logic [16:0]       fa, fb, fdiff;
    logic [24:0]       ft;
    logic [33:0]       e34;
    logic [16:0]       e17;
    logic [SUMW-1:0]   divisor;
    logic [NW-1:0]     numer;
    logic [SUMW:0]     trial;
    logic              ge;
    logic signed [33:0] pv;
    logic signed [OACCW-1:0] oround;

    // effective dimension, clamped to 1..HEAD_DIM
    always_comb begin
        if (r_dim_cfg == 7'd0) begin
            dim = 7'd1;
        end else if (r_dim_cfg > 7'(HEAD_DIM)) begin
            dim = 7'(HEAD_DIM);
        end else begin
            dim = r_dim_cfg;
        end
    end

    assign o_in_ready = (r_state == cah_pkg::ST_IDLE) && (!r_out_valid || i_out_ready);
    assign in_acc     = i_in_valid && o_in_ready;
    assign pos_eff    = i_start_sequence ? '0 : r_pos;
    assign kv_we      = in_acc && ({1'b0, i_dim_index} < dim) && (pos_eff != PW'(MAX_SEQ));
    assign wr_addr    = AW'(pos_eff * HEAD_DIM + i_dim_index);
    assign rd_addr    = AW'(r_j * HEAD_DIM + r_c);
    assign j_last     = (PW'(r_j) == r_pos);
    assign c_last     = (7'(r_c) == dim - 7'd1);
    assign divisor    = (r_sum == '0) ? SUMW'(1) : r_sum;

    // datapath terms
    always_comb begin
        qk     = r_q[r_c] * $signed(r_kdata);
        sr     = (r_sprod + SPW'(1 << 27)) >>> 28;
        if (!sr[SPW-1] && (|sr[SPW-2:31])) begin
            s32 = 32'sh7fffffff;
        end else if (sr[SPW-1] && !(&sr[SPW-2:31])) begin
            s32 = 32'sh80000000;
        end else begin
            s32 = sr[31:0];
        end
        nexp   = {r_max[31], r_max} - {r_sdata[31], r_sdata};
        fa     = cah_pkg::exp_frac({1'b0, nexp[11:8]});
        fb     = cah_pkg::exp_frac(5'({1'b0, nexp[11:8]} + 5'd1));
        fdiff  = fa - fb;
        ft     = 25'(fdiff * nexp[7:0]);
        e34    = 34'(cah_pkg::exp_int(r_i) * r_f) + 34'd32768;
        e17    = r_ez ? 17'd0 : e34[32:16];
        numer  = NW'({r_sdata[16:0], 16'b0}) + NW'(divisor >> 1);
        trial  = {r_rem, r_quo[16]};
        ge     = (trial >= {1'b0, divisor});
        pv     = $signed({1'b0, r_sdata[16:0]}) * $signed(r_vdata);
        oround = (r_oacc + OACCW'(32768)) >>> 16;
    end

    // next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_j         = r_j;
        n_c         = r_c;
        n_dacc      = r_dacc;
        n_sprod     = r_sprod;
        n_max       = r_max;
        n_i         = r_i;
        n_f         = r_f;
        n_ez        = r_ez;
        n_sum       = r_sum;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_cnt       = r_cnt;
        n_oacc      = r_oacc;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_elem  = r_out_elem;
        n_out_index = r_out_index;
        n_out_last  = r_out_last;
        n_seq_full  = r_seq_full;
        sc_we       = 1'b0;
        sc_wdata    = r_sdata;
        unique case (r_state)
            cah_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_pos = pos_eff;
                    if (({1'b0, i_dim_index} == dim - 7'd1)) begin
                        if (pos_eff == PW'(MAX_SEQ)) begin
                            n_out_valid = 1'b1;
                            n_out_elem  = '0;
                            n_out_index = i_dim_index;
                            n_out_last  = 1'b1;
                            n_seq_full  = 1'b1;
                        end else begin
                            n_j     = '0;
                            n_c     = '0;
                            n_dacc  = '0;
                            n_state = cah_pkg::ST_SC_RD;
                        end
                    end
                end
            end
            // dot products
            cah_pkg::ST_SC_RD: n_state = cah_pkg::ST_SC_MAC;
            cah_pkg::ST_SC_MAC: begin
                n_dacc = r_dacc + DACCW'(qk);
                if (c_last) begin
                    n_c     = '0;
                    n_state = cah_pkg::ST_SC_SCL;
                end else begin
                    n_c     = r_c + CW'(1);
                    n_state = cah_pkg::ST_SC_RD;
                end
            end
            cah_pkg::ST_SC_SCL: begin
                n_sprod = r_dacc * $signed({1'b0, r_scale});
                n_state = cah_pkg::ST_SC_WR;
            end
            cah_pkg::ST_SC_WR: begin
                sc_we    = 1'b1;
                sc_wdata = s32;
                if (r_j == '0 || s32 > r_max) begin
                    n_max = s32;
                end
                n_dacc = '0;
                if (j_last) begin
                    n_j     = '0;
                    n_sum   = '0;
                    n_state = cah_pkg::ST_EX_RD;
                end else begin
                    n_j     = r_j + SAW'(1);
                    n_state = cah_pkg::ST_SC_RD;
                end
            end
            // exponentials
            cah_pkg::ST_EX_RD: n_state = cah_pkg::ST_EX_F;
            cah_pkg::ST_EX_F: begin
                n_ez    = ($unsigned(nexp) >= cah_pkg::EXP_LIMIT);
                n_i     = nexp[15:12];
                n_f     = fa - ft[24:8];
                n_state = cah_pkg::ST_EX_E;
            end
            cah_pkg::ST_EX_E: begin
                sc_we    = 1'b1;
                sc_wdata = 32'(e17);
                n_sum    = r_sum + SUMW'(e17);
                if (j_last) begin
                    n_j     = '0;
                    n_state = cah_pkg::ST_NM_RD;
                end else begin
                    n_j     = r_j + SAW'(1);
                    n_state = cah_pkg::ST_EX_RD;
                end
            end
            // normalization, one quotient bit per cycle
            cah_pkg::ST_NM_RD: n_state = cah_pkg::ST_NM_LD;
            cah_pkg::ST_NM_LD: begin
                n_rem   = numer[NW-1:17];
                n_quo   = numer[16:0];
                n_cnt   = 5'd16;
                n_state = cah_pkg::ST_NM_DIV;
            end
            cah_pkg::ST_NM_DIV: begin
                n_rem = ge ? SUMW'(trial - {1'b0, divisor}) : trial[SUMW-1:0];
                n_quo = {r_quo[15:0], ge};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == 5'd0) begin
                    n_state = cah_pkg::ST_NM_WR;
                end
            end
            cah_pkg::ST_NM_WR: begin
                sc_we    = 1'b1;
                sc_wdata = 32'(r_quo);
                if (j_last) begin
                    n_j     = '0;
                    n_c     = '0;
                    n_oacc  = '0;
                    n_state = cah_pkg::ST_OUT_RD;
                end else begin
                    n_j     = r_j + SAW'(1);
                    n_state = cah_pkg::ST_NM_RD;
                end
            end
            // weighted value sums
            cah_pkg::ST_OUT_RD: n_state = cah_pkg::ST_OUT_MAC;
            cah_pkg::ST_OUT_MAC: begin
                n_oacc = r_oacc + OACCW'(pv);
                if (j_last) begin
                    n_state = cah_pkg::ST_OUT_EMIT;
                end else begin
                    n_j     = r_j + SAW'(1);
                    n_state = cah_pkg::ST_OUT_RD;
                end
            end
            cah_pkg::ST_OUT_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    if (!oround[OACCW-1] && (|oround[OACCW-2:15])) begin
                        n_out_elem = 16'sh7fff;
                    end else if (oround[OACCW-1] && !(&oround[OACCW-2:15])) begin
                        n_out_elem = 16'sh8000;
                    end else begin
                        n_out_elem = oround[15:0];
                    end
                    n_out_index = 6'(r_c);
                    n_out_last  = c_last;
                    n_seq_full  = 1'b0;
                    n_oacc      = '0;
                    n_j         = '0;
                    if (c_last) begin
                        n_pos   = r_pos + PW'(1);
                        n_state = cah_pkg::ST_IDLE;
                    end else begin
                        n_c     = r_c + CW'(1);
                        n_state = cah_pkg::ST_OUT_RD;
                    end
                end
            end
            default: n_state = cah_pkg::ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cah_pkg::ST_IDLE;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            r_dim_cfg   <= 7'd16;
            r_scale     <= 16'd16384;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    cah_pkg::CFG_HEAD_DIM: r_dim_cfg <= i_cfg_data[6:0];
                    cah_pkg::CFG_SCALE:    r_scale   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_j         <= n_j;
        r_c         <= n_c;
        r_dacc      <= n_dacc;
        r_sprod     <= n_sprod;
        r_max       <= n_max;
        r_i         <= n_i;
        r_f         <= n_f;
        r_ez        <= n_ez;
        r_sum       <= n_sum;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_cnt       <= n_cnt;
        r_oacc      <= n_oacc;
        r_out_elem  <= n_out_elem;
        r_out_index <= n_out_index;
        r_out_last  <= n_out_last;
        r_seq_full  <= n_seq_full;
        if (kv_we) begin
            r_q[i_dim_index[CW-1:0]] <= i_query_elem;
        end
    end

    // key and value position memories
    always_ff @(posedge i_clk) begin
        if (kv_we) begin
            key_mem[wr_addr] <= i_key_elem;
            val_mem[wr_addr] <= i_value_elem;
        end
        r_kdata <= key_mem[rd_addr];
        r_vdata <= val_mem[rd_addr];
    end

    // score / probability memory
    always_ff @(posedge i_clk) begin
        if (sc_we) begin
            sc_mem[r_j] <= sc_wdata;
        end
        r_sdata <= sc_mem[r_j];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_elem  = r_out_elem;
    assign o_out_index = r_out_index;
    assign o_out_last  = r_out_last;
    assign o_seq_full  = r_seq_full;

    // checks
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == cah_pkg::ST_IDLE))
        else $error("input ready outside idle");
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(MAX_SEQ))
        else $error("position beyond capacity");
    a_full_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_seq_full) |-> r_out_last)
        else $error("full flag without last");
    a_j_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != cah_pkg::ST_IDLE) |-> (PW'(r_j) <= r_pos))
        else $error("position index beyond stored positions");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Causal attention head testbench
// Drives query/key/value element transactions into the attention head,
// predicts every output transaction with a fixed-point softmax model held in
// a scoreboard class, and checks outputs in order under random stalls on
// both channels, several register settings and a full position memory.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SEQ_DEPTH  = 256;
    localparam int VEC_DEPTH  = 16;
    localparam int CYCLE_CAP  = 20_000_000;
    localparam int SETTLE_CYC = 64;

    typedef struct {
        logic signed [15:0] elem;
        logic [5:0]         index;
        logic               last;
        logic               full;
    } t_attn_out;

    // ------------------------------------------------------------------
    // Scoreboard: softmax predictor plus in-order result check
    // ------------------------------------------------------------------
    class attn_scoreboard;
        int unsigned dim_reg   = 16;
        int unsigned scale_reg = 16384;
        int          position  = 0;
        int          key_mem[SEQ_DEPTH*VEC_DEPTH];
        int          val_mem[SEQ_DEPTH*VEC_DEPTH];
        int          query_vec[VEC_DEPTH];
        t_attn_out   awaited_q[$];
        int          mismatches = 0;
        int          checked    = 0;
        int          tokens     = 0;
        int          drops      = 0;

        function int active_dim();
            if (dim_reg < 1) return 1;
            if (dim_reg > VEC_DEPTH) return VEC_DEPTH;
            return int'(dim_reg);
        endfunction

        // exp(-n), n in Q.12, result Q0.16
        function longint unsigned neg_exp(longint n);
            longint unsigned int_tab[12] = '{65536, 24109, 8869, 3263, 1200, 442,
                                             162, 60, 22, 8, 3, 1};
            longint unsigned frac_tab[17] = '{65536, 61565, 57835, 54331, 51039,
                                              47947, 45042, 42313, 39750, 37341,
                                              35079, 32954, 30957, 29081, 27319,
                                              25664, 24109};
            longint unsigned a, b, f;
            int ip, kp, rp;
            if (n >= 49152) return 0;
            ip = int'(n >>> 12);
            kp = int'((n >>> 8) & 15);
            rp = int'(n & 255);
            a = frac_tab[kp];
            b = frac_tab[kp+1];
            f = a - (((a - b) * rp) >> 8);
            return (int_tab[ip] * f + 32768) >> 16;
        endfunction

        function void note_input(bit start, int d, int q, int k, int v);
            longint          score[SEQ_DEPTH];
            longint unsigned prob[SEQ_DEPTH];
            longint          acc, mx;
            longint unsigned total;
            t_attn_out       r;
            int              dim, n;
            if (start) position = 0;
            dim = active_dim();
            if (d >= dim) return;
            if (position >= SEQ_DEPTH) begin
                if (d == dim - 1) begin
                    r.elem = '0; r.index = 6'(d); r.last = 1'b1; r.full = 1'b1;
                    awaited_q.push_back(r);
                    drops++;
                end
                return;
            end
            query_vec[d] = q;
            key_mem[position*VEC_DEPTH + d] = k;
            val_mem[position*VEC_DEPTH + d] = v;
            if (d != dim - 1) return;
            n = position + 1;
            // scaled dot products, rounded half up, clamped to 32 bits
            for (int j = 0; j < n; j++) begin
                acc = 0;
                for (int c = 0; c < dim; c++)
                    acc += longint'(query_vec[c]) * key_mem[j*VEC_DEPTH + c];
                acc = (acc * longint'(scale_reg) + (64'sd1 <<< 27)) >>> 28;
                if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                score[j] = acc;
            end
            mx = score[0];
            for (int j = 1; j < n; j++)
                if (score[j] > mx) mx = score[j];
            total = 0;
            for (int j = 0; j < n; j++) begin
                prob[j] = neg_exp(mx - score[j]);
                total += prob[j];
            end
            if (total == 0) total = 1;
            for (int j = 0; j < n; j++)
                prob[j] = ((prob[j] << 16) + total / 2) / total;
            // weighted value sums
            for (int c = 0; c < dim; c++) begin
                acc = 0;
                for (int j = 0; j < n; j++)
                    acc += longint'(prob[j]) * val_mem[j*VEC_DEPTH + c];
                acc = (acc + 32768) >>> 16;
                if (acc > 32767) acc = 32767;
                if (acc < -32768) acc = -32768;
                r.elem = 16'(acc); r.index = 6'(c);
                r.last = (c == dim - 1); r.full = 1'b0;
                awaited_q.push_back(r);
            end
            position++;
            tokens++;
        endfunction

        function void check_result(t_attn_out got);
            t_attn_out want;
            checked++;
            if (awaited_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected output elem=%0d index=%0d last=%0b full=%0b",
                             got.elem, got.index, got.last, got.full);
                return;
            end
            want = awaited_q.pop_front();
            if (got.elem !== want.elem || got.index !== want.index ||
                got.last !== want.last || got.full !== want.full) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR: output %0d exp elem=%0d idx=%0d last=%0b full=%0b,",
                              " got elem=%0d idx=%0d last=%0b full=%0b"},
                             checked, want.elem, want.index, want.last, want.full,
                             got.elem, got.index, got.last, got.full);
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic               i_cfg_index;
    logic [15:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_start_sequence;
    logic [5:0]         i_dim_index;
    logic signed [15:0] i_query_elem;
    logic signed [15:0] i_key_elem;
    logic signed [15:0] i_value_elem;
    logic               o_out_valid;
    logic               i_out_ready;
    logic signed [15:0] o_out_elem;
    logic [5:0]         o_out_index;
    logic               o_out_last;
    logic               o_seq_full;

    attn_scoreboard sb = new();
    int  cycle_count   = 0;
    bit  burst_mode    = 0;
    bit  hold_done     = 0;
    bit  seq_open      = 0;

    causal_attention_head_forward #(
        .MAX_SEQ  (SEQ_DEPTH),
        .HEAD_DIM (VEC_DEPTH)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_start_sequence (i_start_sequence),
        .i_dim_index      (i_dim_index),
        .i_query_elem     (i_query_elem),
        .i_key_elem       (i_key_elem),
        .i_value_elem     (i_value_elem),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_elem       (o_out_elem),
        .o_out_index      (o_out_index),
        .o_out_last       (o_out_last),
        .o_seq_full       (o_seq_full)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none during bursts
    function automatic int idle_len();
        int roll;
        if (burst_mode) return 0;
        roll = $urandom_range(99);
        if (roll < 65) return 0;
        if (roll < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [15:0] rand_elem();
        int roll;
        roll = $urandom_range(15);
        if (roll == 0) return 16'h7FFF;
        if (roll == 1) return 16'h8000;
        if (roll == 2) return 16'h0000;
        return 16'($urandom_range(65535));
    endfunction

    // output side: checks each transaction, random backpressure, one long hold
    initial begin
        t_attn_out got;
        int        gap;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) begin
                got.elem = o_out_elem; got.index = o_out_index;
                got.last = o_out_last; got.full = o_seq_full;
                sb.check_result(got);
            end
            // hold longer than one token's work so the input stalls too
            if (!hold_done && sb.checked >= 150) begin
                hold_done = 1;
                i_out_ready <= 1'b0;
                repeat (6000) @(posedge i_clk);
            end
            gap = idle_len();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap - 1) @(posedge i_clk);
            end
            // ready high for the next edge
            if (gap > 0) begin
                @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    task automatic write_reg(logic idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == cah_pkg::CFG_HEAD_DIM) sb.dim_reg = data[6:0];
        else sb.scale_reg = data;
    endtask

    // stop offering, wait for all outputs, then let the block settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.awaited_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic send_item(bit start, int d, logic [15:0] q, logic [15:0] k,
                             logic [15:0] v);
        int gap;
        i_in_valid       <= 1'b1;
        i_start_sequence <= start;
        i_dim_index      <= 6'(d);
        i_query_elem     <= q;
        i_key_elem       <= k;
        i_value_elem     <= v;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(start, d, $signed(q), $signed(k), $signed(v));
        gap = idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // one whole token, elements in order, with noise and rewrites mixed in
    task automatic send_token(bit start);
        int dim;
        bit first;
        dim   = sb.active_dim();
        first = start;
        for (int e = 0; e < dim; e++) begin
            if (!burst_mode && dim < 64 && $urandom_range(9) == 0) begin
                send_item(first, $urandom_range(63, dim), rand_elem(), rand_elem(),
                          rand_elem());
                first = 0;
            end
            if (!burst_mode && e > 0 && $urandom_range(11) == 0) begin
                send_item(first, $urandom_range(e - 1), rand_elem(), rand_elem(),
                          rand_elem());
                first = 0;
            end
            send_item(first, e, rand_elem(), rand_elem(), rand_elem());
            first = 0;
        end
        if ($urandom_range(9) == 0) burst_mode = ~burst_mode;
    endtask

    // one register setting, a budget of items, fresh sequence at the start
    task automatic run_phase(int dim_val, int scale_val, int budget);
        int base;
        drain();
        write_reg(cah_pkg::CFG_HEAD_DIM, 16'(dim_val));
        write_reg(cah_pkg::CFG_SCALE, 16'(scale_val));
        base = sb.checked + sb.awaited_q.size();
        send_token(1);
        while (sb.tokens * 0 + base >= 0 && budget > 0) begin
            budget -= sb.active_dim();
            send_token($urandom_range(7) == 0);
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        i_cfg_we         <= 1'b0;
        i_cfg_index      <= cah_pkg::CFG_HEAD_DIM;
        i_cfg_data       <= '0;
        i_in_valid       <= 1'b0;
        i_start_sequence <= 1'b0;
        i_dim_index      <= '0;
        i_query_elem     <= '0;
        i_key_elem       <= '0;
        i_value_elem     <= '0;
        i_out_ready      <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes with a one-element vector and full scale
        write_reg(cah_pkg::CFG_HEAD_DIM, 16'd1);
        write_reg(cah_pkg::CFG_SCALE, 16'hFFFF);
        send_item(1, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_item(0, 0, 16'h8000, 16'h8000, 16'h8000);
        send_item(0, 0, 16'h7FFF, 16'h8000, 16'h7FFF);
        send_item(0, 63, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(0, 0, 16'h0000, 16'h0000, 16'h0000);
        send_item(1, 0, 16'h8000, 16'h7FFF, 16'h8000);
        send_item(0, 0, 16'h8000, 16'h8000, 16'h7FFF);
        // zero scale: flat softmax over two positions
        drain();
        write_reg(cah_pkg::CFG_HEAD_DIM, 16'd2);
        write_reg(cah_pkg::CFG_SCALE, 16'd0);
        send_item(1, 0, 16'h7FFF, 16'h1000, 16'h7FFF);
        send_item(0, 1, 16'h8000, 16'h2000, 16'h8000);
        send_item(0, 0, 16'h1234, 16'h8000, 16'h7FFF);
        send_item(0, 5, 16'h0000, 16'h0000, 16'h0000);
        send_item(0, 1, 16'h4321, 16'h7FFF, 16'h7FFF);

        // random phases over several settings
        run_phase(4, $urandom_range(65535), 4);
        run_phase(64, 65535, 0);
        run_phase(3, 0, 3);
        run_phase(1, $urandom_range(65535), 2);
        run_phase($urandom_range(8, 1), $urandom_range(65535), 0);

        // fill the rest of the position memory, then a few dropped tokens
        drain();
        write_reg(cah_pkg::CFG_HEAD_DIM, 16'd1);
        write_reg(cah_pkg::CFG_SCALE, 16'($urandom_range(65535)));
        burst_mode = 1;
        while (sb.position < SEQ_DEPTH) send_token(0);
        for (int t = 0; t < 3; t++) send_token(0);
        burst_mode = 0;

        drain();
        $display("Covered %0d scored tokens and %0d dropped tokens, %0d outputs checked.",
                 sb.tokens, sb.drops, sb.checked);
        if (sb.mismatches == 0 && sb.awaited_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Mismatches: %0d, outputs still awaited: %0d", sb.mismatches,
                     sb.awaited_q.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
